// ===== rtl/k_way_merge_min_select_top_defines.svh =====
// ----------------------------------------------------------------------------
// k-way merge assertion macros
// property wrappers used by the assertions of the top-level file
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_MIN_SELECT_TOP_DEFINES_SVH
`define K_WAY_MERGE_MIN_SELECT_TOP_DEFINES_SVH

`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define KWM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kwm assertion failed");
// condition that must never hold outside reset
`define KWM_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("kwm forbidden condition seen");
`else
`define KWM_ASSERT(label, clk, rst_n, prop)
`define KWM_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants and types of the k-way merge block
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int KWM_MAX_RUNS   = 16;
    localparam int KWM_VALUE_BITS = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } kwm_state_t;

    // control from the sequencer to the min tracker
    typedef struct packed {
        logic clear;
        logic sample;
        logic hit;
    } kwm_scan_ctl_t;

endpackage

// ===== rtl/k_way_merge_min_select_top.sv =====
// ----------------------------------------------------------------------------
// k_way_merge_min_select_top
// k-way merge of sorted runs with a serial minimum scan over a head store
// ----------------------------------------------------------------------------
// The block keeps one head value per run in a small synchronous memory and an
// active flag per run in flip-flops. After reset, or after a done result, the
// first n input transactions (n = run_count clipped to 1..MAX_RUNS) load the
// heads (or mark runs exhausted) and produce no result. From then on each input
// transaction refills the run emitted last, if any, and starts a scan that reads
// runs 0..n-1 from the memory one per cycle; a merging transaction is accepted
// and written, then the n reads run, the last read lands in the drain state and
// the result is emitted once the output register is free. The single memory
// read port makes the reads serial. The smallest active head is emitted with
// its run, the lowest run winning ties; when no run is active a done result
// with zero value fields is emitted and the block goes back to loading. A
// finished result waits in the output register while the next input
// transaction is already accepted. run_count is written through the config
// channel, which is always ready.
// ----------------------------------------------------------------------------
`include "k_way_merge_min_select_top_defines.svh"

module k_way_merge_min_select_top #(
    parameter int MAX_RUNS   = kwm_pkg::KWM_MAX_RUNS,
    parameter int VALUE_BITS = kwm_pkg::KWM_VALUE_BITS,
    parameter int IDX_BITS   = $clog2(MAX_RUNS),
    parameter int CNT_BITS   = $clog2(MAX_RUNS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CNT_BITS-1:0]   run_count,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic        [IDX_BITS-1:0]   run_index,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  logic                         run_empty,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic        [IDX_BITS-1:0]   out_run,
    output logic                         merge_done
);

    kwm_pkg::kwm_state_t state_reg, state_next;

    // configuration and merge bookkeeping
    logic [CNT_BITS-1:0] run_count_reg;
    logic [MAX_RUNS-1:0] active_reg;
    logic [CNT_BITS-1:0] loaded_reg;
    logic [CNT_BITS-1:0] loaded_inc;
    logic                merging_reg;
    logic [IDX_BITS-1:0] last_run_reg;
    logic                last_valid_reg;

    // scan pipeline
    logic [IDX_BITS-1:0] issue_reg;
    logic                rd_valid_reg;
    logic [IDX_BITS-1:0] rd_idx_reg;
    logic                rd_en;
    logic signed [VALUE_BITS-1:0] rd_data;

    // output register
    logic                         out_valid_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic        [IDX_BITS-1:0]   out_run_reg;
    logic                         merge_done_reg;

    logic                   in_accept;
    logic                   out_free;
    logic                   emit_take;
    logic                   emit_done;
    logic [CNT_BITS-1:0]    eff_cnt;
    logic [CNT_BITS-1:0]    eff_cnt_m1;
    logic [IDX_BITS-1:0]    eff_last;
    logic                   idx_ok;
    logic                   head_we;
    logic [IDX_BITS-1:0]    head_addr;

    kwm_pkg::kwm_scan_ctl_t       scan_ctl;
    logic                         scan_found;
    logic signed [VALUE_BITS-1:0] scan_best_value;
    logic        [IDX_BITS-1:0]   scan_best_run;

    // run count clipped to 1..MAX_RUNS
    always_comb
    begin
        if (run_count_reg == '0)
        begin
            eff_cnt = CNT_BITS'(1);
        end
        else if (run_count_reg > CNT_BITS'(MAX_RUNS))
        begin
            eff_cnt = CNT_BITS'(MAX_RUNS);
        end
        else
        begin
            eff_cnt = run_count_reg;
        end
    end

    assign eff_cnt_m1 = eff_cnt - CNT_BITS'(1);
    assign eff_last   = eff_cnt_m1[IDX_BITS-1:0];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= CNT_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            run_count_reg <= run_count;
        end
    end

    // handshakes
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_take = (state_reg == kwm_pkg::ST_EMIT) && out_free;
    assign emit_done = emit_take && !scan_found;

    // loading indices beyond the store are dropped but still counted
    assign idx_ok    = (int'(run_index) < MAX_RUNS);
    // loading writes at run_index, merging refills the run emitted last
    assign head_we   = in_accept && (merging_reg ? last_valid_reg : idx_ok);
    assign head_addr = merging_reg ? last_run_reg : run_index;

    assign loaded_inc = (&loaded_reg) ? loaded_reg : loaded_reg + CNT_BITS'(1);

    // sequencer: accept, serial read sweep, drain, emit
    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        rd_en           = 1'b0;
        scan_ctl.clear  = 1'b0;
        scan_ctl.sample = rd_valid_reg;
        scan_ctl.hit    = active_reg[rd_idx_reg];
        unique case (state_reg)
            kwm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && merging_reg)
                begin
                    state_next     = kwm_pkg::ST_SCAN;
                    scan_ctl.clear = 1'b1;
                end
            end
            kwm_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
                if (issue_reg == eff_last)
                begin
                    state_next = kwm_pkg::ST_DRAIN;
                end
            end
            kwm_pkg::ST_DRAIN:
            begin
                state_next = kwm_pkg::ST_EMIT;
            end
            kwm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = kwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kwm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // read address sweep and read-data tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            rd_idx_reg   <= issue_reg;
            if (in_accept)
            begin
                issue_reg <= '0;
            end
            else if (rd_en)
            begin
                issue_reg <= issue_reg + IDX_BITS'(1);
            end
        end
    end

    // active flags: set on a head write, cleared on exhaustion or at done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (emit_done)
        begin
            active_reg <= '0;
        end
        else if (head_we)
        begin
            active_reg[head_addr] <= !run_empty;
        end
    end

    // loading count, phase and the run to refill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg     <= '0;
            merging_reg    <= 1'b0;
            last_run_reg   <= '0;
            last_valid_reg <= 1'b0;
        end
        else if (emit_done)
        begin
            loaded_reg     <= '0;
            merging_reg    <= 1'b0;
            last_run_reg   <= '0;
            last_valid_reg <= 1'b0;
        end
        else if (emit_take)
        begin
            last_run_reg   <= scan_best_run;
            last_valid_reg <= 1'b1;
        end
        else if (in_accept && !merging_reg)
        begin
            loaded_reg <= loaded_inc;
            if (loaded_inc >= eff_cnt)
            begin
                merging_reg <= 1'b1;
            end
        end
    end

    kwm_head_mem #(
        .DEPTH     (MAX_RUNS),
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (VALUE_BITS)
    ) u_head_mem (
        .clk     (clk),
        .wr_en   (head_we && !run_empty),
        .wr_addr (head_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (issue_reg),
        .rd_data (rd_data)
    );

    kwm_scan #(
        .IDX_BITS   (IDX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .cand_value (rd_data),
        .cand_run   (rd_idx_reg),
        .found      (scan_found),
        .best_value (scan_best_value),
        .best_run   (scan_best_run)
    );

    // output register, refilled only once the previous transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_take)
        begin
            out_value_reg  <= scan_found ? scan_best_value : '0;
            out_run_reg    <= scan_found ? scan_best_run : '0;
            merge_done_reg <= !scan_found;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_run    = out_run_reg;
    assign merge_done = merge_done_reg;

    // a merging transaction always starts a sweep
    `KWM_ASSERT(a_merge_starts_scan, clk, rst_n,
        (in_accept && merging_reg) |=> (state_reg == kwm_pkg::ST_SCAN))
    // the sweep only runs in the merging phase
    `KWM_NEVER(a_scan_only_merging, clk, rst_n,
        (state_reg != kwm_pkg::ST_IDLE) && !merging_reg)
    // a done result carries zero value fields
    `KWM_ASSERT(a_done_zero_fields, clk, rst_n,
        (out_valid_reg && merge_done_reg) |-> (out_value_reg == '0 && out_run_reg == '0))
    // reads never run past the clipped run count
    `KWM_NEVER(a_read_in_range, clk, rst_n,
        rd_en && (issue_reg > eff_last))

endmodule

// ===== rtl/kwm_head_mem.sv =====
// ----------------------------------------------------------------------------
// kwm_head_mem
// head value store, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module kwm_head_mem #(
    parameter int DEPTH     = kwm_pkg::KWM_MAX_RUNS,
    parameter int ADDR_BITS = $clog2(kwm_pkg::KWM_MAX_RUNS),
    parameter int DATA_BITS = kwm_pkg::KWM_VALUE_BITS
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/kwm_scan.sv =====
// ----------------------------------------------------------------------------
// kwm_scan
// running minimum over the head values streamed out of the store
// ----------------------------------------------------------------------------
module kwm_scan #(
    parameter int IDX_BITS   = $clog2(kwm_pkg::KWM_MAX_RUNS),
    parameter int VALUE_BITS = kwm_pkg::KWM_VALUE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kwm_pkg::kwm_scan_ctl_t       ctl,
    input  logic signed [VALUE_BITS-1:0] cand_value,
    input  logic        [IDX_BITS-1:0]   cand_run,
    output logic                         found,
    output logic signed [VALUE_BITS-1:0] best_value,
    output logic        [IDX_BITS-1:0]   best_run
);

    logic                         found_reg;
    logic signed [VALUE_BITS-1:0] best_value_reg;
    logic        [IDX_BITS-1:0]   best_run_reg;
    logic                         take;

    // strict less-than keeps the lowest index on ties
    assign take = ctl.sample && ctl.hit && (!found_reg || (cand_value < best_value_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_value_reg <= cand_value;
            best_run_reg   <= cand_run;
        end
    end

    assign found      = found_reg;
    assign best_value = best_value_reg;
    assign best_run   = best_run_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the k-way merge block against a cycle-free model of the merge
// ----------------------------------------------------------------------------
// A short directed part covers the run count extremes, ghost and repeated
// loading indices, ties, the most positive and most negative values, and a
// count change in the middle of a merge. A random part then runs merge
// sessions built from sorted runs, mixed with noise transactions and count
// changes. Each accepted input transaction is fed to a local model that
// queues the expected output transactions; a checker compares every
// accepted output transaction with the oldest one in the queue.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD    = 20;
    localparam int IDX_W         = $clog2(kwm_pkg::KWM_MAX_RUNS);
    localparam int CNT_W         = $clog2(kwm_pkg::KWM_MAX_RUNS + 1);
    localparam int VAL_W         = kwm_pkg::KWM_VALUE_BITS;
    localparam int POOL_DEPTH    = 16;
    localparam int TARGET_ITEMS  = 1750;
    // longest merging transaction plus margin
    localparam int SETTLE_CYCLES = kwm_pkg::KWM_MAX_RUNS + 8;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // one output transaction of the block
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] run;
        logic             done;
    } merge_pick_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CNT_W-1:0]        run_count;
    logic                    in_valid;
    logic                    in_stall;
    logic [IDX_W-1:0]        run_index;
    logic signed [VAL_W-1:0] in_value;
    logic                    run_empty;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [VAL_W-1:0] out_value;
    logic [IDX_W-1:0]        out_run;
    logic                    merge_done;

    // merge model state, mirrors the block after reset
    logic [CNT_W-1:0]        cfg_runs = CNT_RESET;
    logic signed [VAL_W-1:0] head_val [kwm_pkg::KWM_MAX_RUNS];
    bit                      head_live [kwm_pkg::KWM_MAX_RUNS] = '{default: 1'b0};
    logic [4:0]              fill_count = '0;
    bit                      in_merge = 1'b0;
    int                      prev_run = 0;
    bit                      prev_ok = 1'b0;

    merge_pick_t             expected_picks [$];
    int                      err_count = 0;
    int                      items_sent = 0;
    // random idling on both sides, off for some stretches
    bit                      idle_on = 1'b1;
    // input valid left high for a back-to-back transaction
    bit                      feeding = 1'b0;

    // sorted runs of the current random session
    logic signed [VAL_W-1:0] run_pool [kwm_pkg::KWM_MAX_RUNS][POOL_DEPTH];
    int                      run_len [kwm_pkg::KWM_MAX_RUNS];
    int                      rd_ptr [kwm_pkg::KWM_MAX_RUNS];

    k_way_merge_min_select_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .run_count  (run_count),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .run_index  (run_index),
        .in_value   (in_value),
        .run_empty  (run_empty),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .out_run    (out_run),
        .merge_done (merge_done)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // merge model
    // ------------------------------------------------------------------------

    // count clipped to 1..MAX_RUNS
    function automatic int live_span();
        if (cfg_runs == 0)
            return 1;
        if (cfg_runs > kwm_pkg::KWM_MAX_RUNS)
            return kwm_pkg::KWM_MAX_RUNS;
        return int'(cfg_runs);
    endfunction

    // empty marks the run exhausted, otherwise the value becomes its head
    function automatic void store_head(int idx, logic signed [VAL_W-1:0] val, logic empty);
        if (empty)
        begin
            head_live[idx] = 1'b0;
        end
        else
        begin
            head_val[idx]  = val;
            head_live[idx] = 1'b1;
        end
    endfunction

    // applies one accepted input transaction, queues its result if any
    function automatic void predict_merge_step(logic [IDX_W-1:0] idx,
                                               logic signed [VAL_W-1:0] val,
                                               logic empty);
        merge_pick_t pick;
        int          n;
        int          best;
        bit          found;
        n     = live_span();
        best  = 0;
        found = 1'b0;
        if (!in_merge)
        begin
            store_head(int'(idx), val, empty);
            if (fill_count < 31)
                fill_count++;
            if (fill_count >= n)
                in_merge = 1'b1;
            return;
        end
        // refill goes to the run emitted last, never to run_index
        if (prev_ok)
            store_head(prev_run, val, empty);
        // strict compare keeps the lowest run on ties
        for (int i = 0; i < n; i++)
        begin
            if (head_live[i] && (!found || head_val[i] < head_val[best]))
            begin
                found = 1'b1;
                best  = i;
            end
        end
        if (!found)
        begin
            head_live  = '{default: 1'b0};
            fill_count = '0;
            in_merge   = 1'b0;
            prev_ok    = 1'b0;
            prev_run   = 0;
            pick.value = '0;
            pick.run   = '0;
            pick.done  = 1'b1;
        end
        else
        begin
            prev_run   = best;
            prev_ok    = 1'b1;
            pick.value = head_val[best];
            pick.run   = IDX_W'(best);
            pick.done  = 1'b0;
        end
        expected_picks.push_back(pick);
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one input transaction, held until accepted, then an optional gap
    task automatic send_item(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
                             input logic empty);
        int gap;
        in_valid  <= 1'b1;
        run_index <= idx;
        in_value  <= val;
        run_empty <= empty;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_merge_step(idx, val, empty);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            feeding = 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            feeding = 1'b1;
        end
    endtask

    // drop a valid left high by the last transaction
    task automatic park_input();
        if (feeding)
        begin
            in_valid <= 1'b0;
            feeding = 1'b0;
            @(posedge clk);
        end
    endtask

    // sender holds off until every expected result has come out
    task automatic hold_until_drained();
        park_input();
        while (expected_picks.size() != 0)
            @(posedge clk);
    endtask

    // loading transactions give no result, so let the block settle too
    task automatic settle_block();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // config channel write, only called once the block is idle
    task automatic write_run_count(input logic [CNT_W-1:0] cnt);
        cfg_valid <= 1'b1;
        run_count <= cnt;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_runs = cnt;
        cfg_valid <= 1'b0;
    endtask

    // output stall pattern, bursts of stall between bursts of flow
    initial
    begin : out_stall_gen
        int  hold;
        bit  stalling;
        hold     = 0;
        stalling = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idle_on)
            begin
                stalling = 1'b0;
                hold     = 0;
                out_stall <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else if (stalling)
            begin
                stalling = 1'b0;
                hold     = $urandom_range(0, 6);
                out_stall <= 1'b0;
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    stalling = 1'b1;
                    hold--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    hold = $urandom_range(0, 4);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        merge_pick_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_picks.size() == 0)
            begin
                $error("unexpected out transaction: value %0d run %0d done %0b",
                       out_value, out_run, merge_done);
                err_count++;
            end
            else
            begin
                want = expected_picks.pop_front();
                if (merge_done !== want.done)
                begin
                    $error("merge_done: expected %0b, got %0b", want.done, merge_done);
                    err_count++;
                end
                if (out_value !== $signed(want.value))
                begin
                    $error("out_value: expected %0d, got %0d", $signed(want.value), out_value);
                    err_count++;
                end
                if (out_run !== want.run)
                begin
                    $error("out_run: expected %0d, got %0d", want.run, out_run);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // count from reset is 1, the most positive value must come out
    task automatic test_default_count();
        send_item(IDX_W'(0), VAL_MAX, 1'b0);
        // first merging transaction only starts the scan
        send_item(IDX_W'(5), 32'h1234_5678, 1'b1);
        send_item(IDX_W'(0), VAL_W'(0), 1'b1);
    endtask

    // count 0 acts as 1; a head past the count is written but never scanned
    task automatic test_count_floor_and_ghost_run();
        settle_block();
        write_run_count(CNT_W'(0));
        send_item(IDX_W'(3), VAL_W'(5), 1'b0);
        // run 0 never loaded, so the scan finds nothing and reports done
        send_item(IDX_W'(0), VAL_W'(0), 1'b0);
    endtask

    // repeated loading index overwrites, equal heads go to the lower run
    task automatic test_ties_and_overwrite();
        settle_block();
        write_run_count(CNT_W'(3));
        send_item(IDX_W'(1), VAL_MIN, 1'b0);
        send_item(IDX_W'(1), VAL_W'(-7), 1'b0);
        send_item(IDX_W'(2), VAL_W'(-7), 1'b0);
        send_item(IDX_W'(0), VAL_W'(99), 1'b0);
        // index ignored while merging, refill lands on run 1
        send_item(IDX_W'(2), VAL_W'(42), 1'b1);
        send_item(IDX_W'(1), VAL_W'(0), 1'b1);
    endtask

    // count above the maximum clips, count changes take effect at once
    task automatic test_count_change_midstream();
        settle_block();
        write_run_count(CNT_W'(17));
        send_item(IDX_W'(0), VAL_MAX, 1'b0);
        send_item(IDX_W'(15), VAL_MIN, 1'b0);
        // still loading, shrink the count so the next load starts the merge
        settle_block();
        write_run_count(CNT_W'(2));
        send_item(IDX_W'(1), VAL_W'(0), 1'b0);
        send_item(IDX_W'(7), VAL_W'(1), 1'b1);
        // widen the scan in the middle of the merge, run 15 now wins
        settle_block();
        write_run_count(CNT_W'(kwm_pkg::KWM_MAX_RUNS));
        send_item(IDX_W'(1), VAL_W'(3), 1'b1);
        send_item(IDX_W'(4), VAL_W'(8), 1'b1);
        // equal refill of the top value
        send_item(IDX_W'(0), VAL_MAX, 1'b0);
        send_item(IDX_W'(0), VAL_W'(0), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // random merging
    // ------------------------------------------------------------------------

    // transactions with no structure at all
    task automatic send_noise(input int count);
        repeat (count)
            send_item(IDX_W'($urandom_range(0, kwm_pkg::KWM_MAX_RUNS - 1)), $urandom(),
                      ($urandom_range(0, 3) == 0));
    endtask

    // one merge of sorted runs: load the heads, then refill until done
    task automatic run_merge_session(input int max_len);
        int     n;
        int     mode;
        int     pick;
        int     k;
        int     tmp;
        int     order [kwm_pkg::KWM_MAX_RUNS];
        longint cur;
        n    = live_span();
        mode = $urandom_range(0, 3);
        for (int r = 0; r < kwm_pkg::KWM_MAX_RUNS; r++)
        begin
            run_len[r] = 0;
            rd_ptr[r]  = 0;
            order[r]   = r;
        end
        for (int r = 0; r < n; r++)
        begin
            run_len[r] = $urandom_range(0, max_len);
            // narrow spread near zero, full range, pinned at the top or bottom
            case (mode)
                0:       cur = longint'(int'($urandom_range(0, 8)) - 4);
                1:       cur = longint'($signed($urandom()));
                2:       cur = longint'(VAL_MAX) - longint'(int'($urandom_range(0, 20)));
                default: cur = longint'(VAL_MIN) + longint'(int'($urandom_range(0, 6)));
            endcase
            for (int j = 0; j < run_len[r]; j++)
            begin
                if (cur > longint'(VAL_MAX))
                    cur = longint'(VAL_MAX);
                run_pool[r][j] = cur[VAL_W-1:0];
                if (mode == 1)
                    cur += longint'(int'($urandom_range(0, 1 << 28)));
                else
                    cur += longint'(int'($urandom_range(0, 2)));
            end
        end
        // loading order shuffled
        for (int r = n - 1; r > 0; r--)
        begin
            k        = $urandom_range(0, r);
            tmp      = order[r];
            order[r] = order[k];
            order[k] = tmp;
        end
        // broken session: one load aimed at a duplicate or a run past the count
        if ($urandom_range(0, 6) == 0)
            order[$urandom_range(0, n - 1)] = $urandom_range(0, kwm_pkg::KWM_MAX_RUNS - 1);
        for (int r = 0; r < n && !in_merge; r++)
        begin
            pick = order[r];
            if (pick >= n)
            begin
                send_item(IDX_W'(pick), $urandom(), 1'($urandom_range(0, 1)));
            end
            else if (rd_ptr[pick] < run_len[pick])
            begin
                send_item(IDX_W'(pick), run_pool[pick][rd_ptr[pick]], 1'b0);
                rd_ptr[pick]++;
            end
            else
            begin
                send_item(IDX_W'(pick), $urandom(), 1'b1);
            end
        end
        while (in_merge)
        begin
            if (!prev_ok)
            begin
                send_item(IDX_W'($urandom_range(0, kwm_pkg::KWM_MAX_RUNS - 1)), $urandom(),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                pick = prev_run;
                // index is ignored while merging, sometimes make it wrong
                k = ($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, kwm_pkg::KWM_MAX_RUNS - 1) : pick;
                if (rd_ptr[pick] < run_len[pick])
                begin
                    send_item(IDX_W'(k), run_pool[pick][rd_ptr[pick]], 1'b0);
                    rd_ptr[pick]++;
                end
                else
                begin
                    send_item(IDX_W'(k), $urandom(), 1'b1);
                end
            end
        end
    endtask

    task automatic test_random_merges();
        int roll;
        while (items_sent < TARGET_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                settle_block();
                if ($urandom_range(0, 1) == 0)
                    write_run_count(CNT_W'($urandom_range(0, CNT_MAX)));
                else
                    case ($urandom_range(0, 4))
                        0:       write_run_count(CNT_W'(0));
                        1:       write_run_count(CNT_W'(1));
                        2:       write_run_count(CNT_W'(kwm_pkg::KWM_MAX_RUNS));
                        3:       write_run_count(CNT_W'(kwm_pkg::KWM_MAX_RUNS + 1));
                        default: write_run_count(CNT_MAX);
                    endcase
            end
            // some sessions run with no idling on either side
            idle_on = ($urandom_range(0, 4) != 0);
            if (roll >= 10 && roll < 18)
                send_noise($urandom_range(1, 6));
            else
                run_merge_session($urandom_range(0, 10));
            if ($urandom_range(0, 15) == 0)
                hold_until_drained();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int drain_wait;
        drain_wait = 0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        run_count <= CNT_RESET;
        in_valid  <= 1'b0;
        run_index <= '0;
        in_value  <= '0;
        run_empty <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_count();
        test_count_floor_and_ghost_run();
        test_ties_and_overwrite();
        test_count_change_midstream();
        test_random_merges();

        // wait for the tail of the results, bounded
        park_input();
        while (expected_picks.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_picks.size() != 0)
        begin
            $error("%0d expected results never came out", expected_picks.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin : run_limit
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_head_mem.sv
rtl/kwm_scan.sv
rtl/k_way_merge_min_select_top.sv
tb/sv/tb_top.sv
